// ----- rtl/rsrt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Router solicitation retry timer package
// Shared types, register indexes, reset values and constants.
// ----------------------------------------------------------------------------
package rsrt_pkg;

    localparam int IFACE_SLOTS        = 4;
    localparam int NUM_INTERFACES_DEF = 4;
    localparam int CFG_IDX_W          = 8;
    localparam int CFG_DATA_W         = 16;
    localparam int DIV_STEPS          = 32;
    localparam int RECIP_SHIFT        = 19;

    localparam logic [15:0] RECIP_10 = 16'hCCCD;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IFACE_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SOLICIT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_IVL     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL      = 8'd3;

    localparam logic [3:0]  RST_IFACE_ENABLE = 4'd0;
    localparam logic [7:0]  RST_MAX_SOLICIT  = 8'd3;
    localparam logic [15:0] RST_INIT_IVL     = 16'd4;
    localparam logic [15:0] RST_MAX_IVL      = 16'd3600;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  iface_sel;
        logic [15:0] start_delay;
        logic [31:0] random_value;
        logic [3:0]  send_blocked;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  send_iface;
        logic        send_ok;
        logic [15:0] next_timer;
        logic        last_of_tick;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic next_idx;
        logic dec;
        logic upd;
        logic mul;
        logic div_init;
        logic div_step;
        logic fin;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic act;
        logic expire;
        logic hold;
        logic div_last;
        logic last_idx;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/rsrt_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Router solicitation retry timer datapath
// Per-interface timer state, configuration registers, jitter unit with a
// serial remainder, and the output word register.
// ----------------------------------------------------------------------------
module rsrt_datapath #(
    parameter int NUM_INTERFACES = rsrt_pkg::NUM_INTERFACES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  rsrt_pkg::t_dp_cmd                  i_cmd,
    output rsrt_pkg::t_dp_status               o_status,
    input  rsrt_pkg::t_in_word                 i_data,
    input  wire                                i_cfg_valid,
    input  wire [rsrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [rsrt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output rsrt_pkg::t_out_word                o_data
);

    localparam int NIF = (NUM_INTERFACES < rsrt_pkg::IFACE_SLOTS) ?
                         NUM_INTERFACES : rsrt_pkg::IFACE_SLOTS;
    localparam logic [1:0] LAST_IDX = 2'(NIF - 1);

    logic [3:0]  r_en;
    logic [7:0]  r_maxsol;
    logic [15:0] r_init;
    logic [15:0] r_maxivl;

    logic [15:0] r_cd  [NIF];
    logic [7:0]  r_rc  [NIF];
    logic [15:0] r_ivl [NIF];

    logic [1:0]  r_idx;
    logic [31:0] r_rnd;
    logic [3:0]  r_blk;
    logic [3:0]  r_mask;
    logic        r_ok;
    logic [15:0] r_jiv;
    logic [12:0] r_spread;
    logic [13:0] r_mod;
    logic [13:0] r_rem;
    logic [31:0] r_dvd;
    logic [4:0]  r_cnt;
    logic [15:0] r_next;
    logic        r_out_valid;
    rsrt_pkg::t_out_word r_out;

    logic [15:0] cur_cd;
    logic [7:0]  cur_rc;
    logic [15:0] cur_ivl;
    logic [15:0] cd_dec;
    logic [16:0] dbl;
    logic [15:0] dbl_clamp;
    logic [15:0] new_ivl;
    logic [7:0]  new_rc;
    logic [31:0] prod;
    logic [14:0] trial;
    logic [13:0] rem_n;
    logic [16:0] jsum;
    logic [15:0] jval;
    logic [3:0]  mask_now;
    logic        last;
    logic        out_free;

    always_comb begin
        cur_cd  = '0;
        cur_rc  = '0;
        cur_ivl = '0;
        for (int j = 0; j < NIF; j++) begin
            if (r_idx == 2'(j)) begin
                cur_cd  = r_cd[j];
                cur_rc  = r_rc[j];
                cur_ivl = r_ivl[j];
            end
        end
    end

    always_comb begin
        mask_now = '0;
        for (int j = 0; j < NIF; j++) begin
            mask_now[j] = r_en[j] && (r_rc[j] != 8'd0) && (r_cd[j] == 16'd1);
        end
        last = 1'b1;
        for (int j = 0; j < rsrt_pkg::IFACE_SLOTS; j++) begin
            if ((3'(j) > {1'b0, r_idx}) && r_mask[j]) begin
                last = 1'b0;
            end
        end
    end

    assign cd_dec    = cur_cd - 16'd1;
    assign dbl       = {cur_ivl, 1'b0};
    assign dbl_clamp = (dbl > {1'b0, r_maxivl}) ? r_maxivl : dbl[15:0];
    assign new_ivl   = (cur_rc > 8'd1) ? cur_ivl : dbl_clamp;
    assign new_rc    = (cur_rc > 8'd1) ? cur_rc - 8'd1 : cur_rc;

    assign prod  = {16'd0, r_jiv} * {16'd0, rsrt_pkg::RECIP_10};
    assign trial = {r_rem, r_dvd[31]};
    assign rem_n = (trial >= {1'b0, r_mod}) ? 14'(trial - {1'b0, r_mod}) : trial[13:0];
    assign jsum  = {1'b0, r_jiv} - {4'd0, r_spread} + {3'd0, r_rem};

    always_comb begin
        jval = jsum[16] ? 16'hFFFF : jsum[15:0];
        if (jval == 16'd0) begin
            jval = 16'd1;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    assign o_status.is_tick  = (i_data.opcode == rsrt_pkg::OP_TICK);
    assign o_status.act      = r_en[r_idx] && (cur_rc != 8'd0);
    assign o_status.expire   = (cur_cd == 16'd1);
    assign o_status.hold     = r_blk[r_idx] && (cur_rc == r_maxsol);
    assign o_status.div_last = (r_cnt == 5'(rsrt_pkg::DIV_STEPS - 1));
    assign o_status.last_idx = (r_idx == LAST_IDX);
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= rsrt_pkg::RST_IFACE_ENABLE;
            r_maxsol <= rsrt_pkg::RST_MAX_SOLICIT;
            r_init   <= rsrt_pkg::RST_INIT_IVL;
            r_maxivl <= rsrt_pkg::RST_MAX_IVL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsrt_pkg::REG_IFACE_ENABLE: r_en     <= i_cfg_data[3:0];
                rsrt_pkg::REG_MAX_SOLICIT:  r_maxsol <= i_cfg_data[7:0];
                rsrt_pkg::REG_INIT_IVL:     r_init   <= i_cfg_data;
                rsrt_pkg::REG_MAX_IVL:      r_maxivl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NIF; j++) begin
                r_cd[j]  <= '0;
                r_rc[j]  <= '0;
                r_ivl[j] <= '0;
            end
        end else begin
            for (int j = 0; j < NIF; j++) begin
                if (i_cmd.accept && i_data.iface_sel == 2'(j)) begin
                    if (i_data.opcode == rsrt_pkg::OP_START) begin
                        r_rc[j]  <= r_maxsol;
                        r_ivl[j] <= r_init;
                        r_cd[j]  <= (i_data.start_delay == 16'd0) ? 16'd1 :
                                    i_data.start_delay;
                    end else if (i_data.opcode == rsrt_pkg::OP_STOP) begin
                        r_rc[j] <= 8'd0;
                    end
                end
                if (r_idx == 2'(j)) begin
                    if (i_cmd.dec) begin
                        r_cd[j] <= cd_dec;
                    end
                    if (i_cmd.upd && !o_status.hold) begin
                        r_rc[j]  <= new_rc;
                        r_ivl[j] <= new_ivl;
                    end
                    if (i_cmd.emit) begin
                        r_cd[j] <= r_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.next_idx) begin
                r_idx <= r_idx + 2'd1;
            end
            if (i_cmd.div_init) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rnd  <= i_data.random_value;
            r_blk  <= i_data.send_blocked;
            r_mask <= mask_now;
        end
        if (i_cmd.upd) begin
            r_ok <= !r_blk[r_idx];
            if (o_status.hold) begin
                r_next <= 16'd1;
            end else begin
                r_jiv <= new_ivl;
            end
        end
        if (i_cmd.mul) begin
            r_spread <= 13'(prod >> rsrt_pkg::RECIP_SHIFT);
        end
        if (i_cmd.div_init) begin
            r_mod <= {r_spread, 1'b1};
            r_rem <= '0;
            r_dvd <= r_rnd;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_n;
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
        if (i_cmd.fin) begin
            r_next <= jval;
        end
        if (i_cmd.emit) begin
            r_out.send_iface   <= r_idx;
            r_out.send_ok      <= r_ok;
            r_out.next_timer   <= r_next;
            r_out.last_of_tick <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ----- rtl/rsrt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Router solicitation retry timer controller
// Sequences the interface scan of a tick and the jitter computation.
// ----------------------------------------------------------------------------
module rsrt_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  rsrt_pkg::t_dp_status    i_status,
    output rsrt_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EVAL = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIVI = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_tick) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (i_status.act && i_status.expire) begin
                    o_cmd.upd = 1'b1;
                    n_state   = i_status.hold ? ST_EMIT : ST_MUL;
                end else begin
                    o_cmd.dec = i_status.act;
                    if (i_status.last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = ST_EVAL;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/router_solicitation_retry_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Router solicitation retry timer
// Per-interface solicitation scheduler with interval backoff and jitter.
// ----------------------------------------------------------------------------
// Start, stop and unknown words stay in ST_IDLE; a tick word moves to ST_EVAL,
// which scans the interfaces in turn. An interface that does not expire needs
// only ST_EVAL; an expiring interface whose send is blocked while its count
// equals the maximum goes straight to ST_EMIT; any other one passes ST_MUL,
// ST_DIVI, ST_DIV and ST_FIN, the jitter remainder unit retiring one bit of
// the 32-bit random word per cycle. ST_EMIT waits until the output register is
// free. Each expiring interface yields one output word, in ascending interface
// order, with last_of_tick set on the final one. The output register lets the
// next input word be taken while the last result still waits. Configuration
// is always ready and must only be written while the block is idle.
module router_solicitation_retry_timer #(
    parameter int NUM_INTERFACES = rsrt_pkg::NUM_INTERFACES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  rsrt_pkg::t_in_word                 i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output rsrt_pkg::t_out_word                o_data,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [rsrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [rsrt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rsrt_pkg::t_dp_cmd    cmd;
    rsrt_pkg::t_dp_status status;

    rsrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rsrt_datapath #(
        .NUM_INTERFACES (NUM_INTERFACES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ----- rtl/rsrt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Router solicitation retry timer checker
// Port-level properties of the timer, bound to the top level.
// ----------------------------------------------------------------------------
module rsrt_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_valid,
    input wire                  o_ready,
    input rsrt_pkg::t_in_word   i_data,
    input wire                  o_valid,
    input wire                  i_ready,
    input rsrt_pkg::t_out_word  o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Output word changed while stalled.");

    a_timer_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.next_timer != 16'd0)
        else $error("Loaded timer is zero.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_no_result_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.opcode != rsrt_pkg::OP_TICK && !o_valid
        |=> !o_valid)
        else $error("Start or stop word produced a result.");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.opcode == rsrt_pkg::OP_TICK |=> !o_ready)
        else $error("Ready stayed high while a tick is scanned.");

endmodule

bind router_solicitation_retry_timer rsrt_checker u_rsrt_checker (.*);
`default_nettype wire
